FILE: rtl/periodic_plane_wrap_unit_defines.svh
// assertion macros for the periodic plane wrap unit
// expects clk and rst_n in scope at the point of use
`ifndef PERIODIC_PLANE_WRAP_UNIT_DEFINES_SVH
`define PERIODIC_PLANE_WRAP_UNIT_DEFINES_SVH

// same-cycle implication
`define PPW_CHECK_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PPW_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/ppw_pkg.sv
// shared types and constants of the periodic plane wrap unit
// no dependencies
`timescale 1ns / 1ps

package ppw_pkg;

  localparam int CMD_W    = 2;
  localparam int PLANE_W  = 4;
  localparam int WORD_W   = 4;
  localparam int COORD_W  = 32;
  localparam int DIR_W    = 18;
  localparam int FRAC_W   = 16;
  localparam int AXES     = 3;

  localparam int PLANES_DEF = 16;

  // geometry row layout
  localparam int WORDS = 12;
  localparam int W_ORG = 0;
  localparam int W_N   = 3;
  localparam int W_T   = 6;
  localparam int W_S   = 9;

  localparam int ROUND_HALF = 1 << (FRAC_W - 1);

  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE   = 2'd0,
    CMD_PARTNER = 2'd1,
    CMD_WRAP    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

endpackage

FILE: rtl/ppw_intf.sv
// request and result channel interfaces of the periodic plane wrap unit
// depends on ppw_pkg
`timescale 1ns / 1ps

interface ppw_in_if;
  logic                                 valid;
  logic                                 ready;
  ppw_pkg::cmd_t                        cmd;
  logic [ppw_pkg::PLANE_W-1:0]          plane;
  logic [ppw_pkg::WORD_W-1:0]           word;
  logic signed [ppw_pkg::COORD_W-1:0]   value;
  logic signed [ppw_pkg::COORD_W-1:0]   point_x;
  logic signed [ppw_pkg::COORD_W-1:0]   point_y;
  logic signed [ppw_pkg::COORD_W-1:0]   point_z;

  modport source (
    output valid, cmd, plane, word, value, point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, plane, word, value, point_x, point_y, point_z,
    output ready
  );
endinterface

interface ppw_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ppw_pkg::COORD_W-1:0]   out_x;
  logic signed [ppw_pkg::COORD_W-1:0]   out_y;
  logic signed [ppw_pkg::COORD_W-1:0]   out_z;
  logic                                 wrapped;
  logic                                 saturated;

  modport source (
    output valid, out_x, out_y, out_z, wrapped, saturated,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, wrapped, saturated,
    output ready
  );
endinterface

FILE: rtl/periodic_plane_wrap_unit.sv
// Periodic plane wrap unit. Takes one request per clock unless the result side stalls, and
// returns one result per request, in order. A request loads one geometry word of a plane,
// sets or clears its partner, or wraps a point against a plane. The unit is a nine-stage
// pipeline: partner lookup, a read of both the tested plane and its partner from the
// row-wide geometry table (two read ports), the differences, the dot product multiplies,
// the dot product sums, rounding, the remap multiplies, the remap sums, and the saturating
// output register. Geometry rows are undefined until loaded. Partner entries come out of
// reset as none, held by one valid flop per plane, so no clearing pass is needed. Table
// writes take effect in request order, so a wrap sees every write sent before it.
`timescale 1ns / 1ps
`include "periodic_plane_wrap_unit_defines.svh"

module periodic_plane_wrap_unit #(
  parameter int PLANES = ppw_pkg::PLANES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  ppw_in_if.sink         in_if,
  ppw_out_if.source      out_if
);

  localparam int STAGES  = 9;
  localparam int PIDX_W  = $clog2(PLANES);
  localparam int CW      = ppw_pkg::COORD_W;
  localparam int DW      = ppw_pkg::DIR_W;
  localparam int FW      = ppw_pkg::FRAC_W;
  localparam int AX      = ppw_pkg::AXES;
  localparam int DIFF_W  = CW + 1;
  localparam int PROD1_W = DIFF_W + DW;
  localparam int DOT_W   = PROD1_W + 2;
  localparam int PROJ_W  = DOT_W - FW;
  localparam int PROD2_W = PROJ_W + DW;
  localparam int ACC_W   = PROD2_W + 2;
  localparam int RES_W   = ACC_W - FW + 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic                 wrapped;
    logic                 saturated;
  } result_t;

  function automatic logic signed [PROJ_W-1:0] round_dot(input logic signed [DOT_W-1:0] d);
    logic signed [DOT_W-1:0] t;
    t = d + DOT_W'(ppw_pkg::ROUND_HALF);
    return $signed(t[DOT_W-1:FW]);
  endfunction

  // pipeline handshake
  logic [STAGES:1] vld_r;
  logic [STAGES:1] rdy;

  always_comb begin
    rdy[STAGES] = !vld_r[STAGES] || out_if.ready;
    for (int k = STAGES - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign in_if.ready = rdy[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[1]) begin
        vld_r[1] <= in_if.valid;
      end
      for (int k = 2; k <= STAGES; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
    end
  end

  // request decode
  logic              in_acc;
  logic              in_range;
  logic              val_ok;
  logic              partner_set;
  logic [PIDX_W-1:0] in_idx;
  logic [PIDX_W-1:0] val_idx;

  assign in_acc      = in_if.valid && rdy[1];
  assign in_range    = int'(in_if.plane) < PLANES;
  assign val_ok      = !in_if.value[CW-1] && (in_if.value[CW-2:0] < (CW-1)'(PLANES));
  assign partner_set = in_acc && in_if.cmd == ppw_pkg::CMD_PARTNER && in_range;
  assign in_idx      = PIDX_W'(in_if.plane);
  assign val_idx     = PIDX_W'(in_if.value);

  // partner table: index in memory, valid bit per plane in flops
  logic [PIDX_W-1:0] partner_mem [PLANES];
  logic [PLANES-1:0] partner_vld_r;
  logic [PIDX_W-1:0] s1_partner_r;

  always_ff @(posedge clk) begin
    if (partner_set && val_ok) begin
      partner_mem[in_idx] <= val_idx;
    end
    if (rdy[1]) begin
      s1_partner_r <= partner_mem[in_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      partner_vld_r <= '0;
    end else if (partner_set) begin
      partner_vld_r[in_idx] <= val_ok;
    end
  end

  // stage 1
  ppw_pkg::cmd_t               s1_cmd_r;
  logic                        s1_in_range_r;
  logic [PIDX_W-1:0]           s1_idx_r;
  logic [ppw_pkg::WORD_W-1:0]  s1_word_r;
  logic [CW-1:0]               s1_value_r;
  logic signed [CW-1:0]        s1_p_r [AX];
  logic                        s1_pvld_r;

  // geometry table, one row of words per plane
  logic [ppw_pkg::WORDS-1:0][CW-1:0] geo_mem [PLANES];
  logic [ppw_pkg::WORDS-1:0][CW-1:0] row_i_r;
  logic [ppw_pkg::WORDS-1:0][CW-1:0] row_j_r;
  logic                              geo_we;

  assign geo_we = vld_r[1] && rdy[2] && s1_cmd_r == ppw_pkg::CMD_WRITE && s1_in_range_r &&
                  (s1_word_r < ppw_pkg::WORD_W'(ppw_pkg::WORDS));

  always_ff @(posedge clk) begin
    if (geo_we) begin
      geo_mem[s1_idx_r][s1_word_r] <= s1_value_r;
    end
    if (rdy[2]) begin
      row_i_r <= geo_mem[s1_idx_r];
      row_j_r <= geo_mem[s1_partner_r];
    end
  end

  // later stage payload
  logic                     s2_is_wrap_r, s2_test_r;
  logic signed [CW-1:0]     s2_p_r [AX];

  logic                     s3_is_wrap_r, s3_test_r;
  logic signed [CW-1:0]     s3_p_r [AX];
  logic signed [DIFF_W-1:0] s3_di_r [AX];
  logic signed [DIFF_W-1:0] s3_dj_r [AX];
  logic signed [DW-1:0]     s3_ni_r [AX];
  logic signed [DW-1:0]     s3_nj_r [AX];
  logic signed [DW-1:0]     s3_tj_r [AX];
  logic signed [DW-1:0]     s3_sj_r [AX];
  logic signed [CW-1:0]     s3_oj_r [AX];

  logic                     s4_is_wrap_r, s4_test_r;
  logic signed [CW-1:0]     s4_p_r [AX];
  logic signed [PROD1_W-1:0] s4_mn_r [AX];
  logic signed [PROD1_W-1:0] s4_mt_r [AX];
  logic signed [PROD1_W-1:0] s4_ms_r [AX];
  logic signed [DW-1:0]     s4_nj_r [AX];
  logic signed [DW-1:0]     s4_tj_r [AX];
  logic signed [DW-1:0]     s4_sj_r [AX];
  logic signed [CW-1:0]     s4_oj_r [AX];

  logic                     s5_is_wrap_r, s5_test_r;
  logic signed [CW-1:0]     s5_p_r [AX];
  logic signed [DOT_W-1:0]  s5_dn_r, s5_dt_r, s5_ds_r;
  logic signed [DW-1:0]     s5_nj_r [AX];
  logic signed [DW-1:0]     s5_tj_r [AX];
  logic signed [DW-1:0]     s5_sj_r [AX];
  logic signed [CW-1:0]     s5_oj_r [AX];

  logic                     s6_is_wrap_r, s6_wrap_r;
  logic signed [CW-1:0]     s6_p_r [AX];
  logic signed [PROJ_W-1:0] s6_qn_r, s6_qt_r, s6_qs_r;
  logic signed [DW-1:0]     s6_nj_r [AX];
  logic signed [DW-1:0]     s6_tj_r [AX];
  logic signed [DW-1:0]     s6_sj_r [AX];
  logic signed [CW-1:0]     s6_oj_r [AX];

  logic                      s7_is_wrap_r, s7_wrap_r;
  logic signed [CW-1:0]      s7_p_r [AX];
  logic signed [PROD2_W-1:0] s7_mn_r [AX];
  logic signed [PROD2_W-1:0] s7_mt_r [AX];
  logic signed [PROD2_W-1:0] s7_ms_r [AX];
  logic signed [CW-1:0]      s7_oj_r [AX];

  logic                     s8_is_wrap_r, s8_wrap_r;
  logic signed [CW-1:0]     s8_p_r [AX];
  logic signed [ACC_W-1:0]  s8_acc_r [AX];
  logic signed [CW-1:0]     s8_oj_r [AX];

  result_t                  out_r;
  result_t                  out_nxt;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_cmd_r      <= in_if.cmd;
      s1_in_range_r <= in_range;
      s1_idx_r      <= in_idx;
      s1_word_r     <= in_if.word;
      s1_value_r    <= in_if.value;
      s1_p_r[0]     <= in_if.point_x;
      s1_p_r[1]     <= in_if.point_y;
      s1_p_r[2]     <= in_if.point_z;
      s1_pvld_r     <= partner_vld_r[in_idx];
    end

    if (rdy[2]) begin
      s2_is_wrap_r <= s1_cmd_r == ppw_pkg::CMD_WRAP;
      s2_test_r    <= s1_cmd_r == ppw_pkg::CMD_WRAP && s1_in_range_r && s1_pvld_r;
      s2_p_r       <= s1_p_r;
    end

    // offsets from both origins, direction fields taken as Q2.16
    if (rdy[3]) begin
      s3_is_wrap_r <= s2_is_wrap_r;
      s3_test_r    <= s2_test_r;
      s3_p_r       <= s2_p_r;
      for (int k = 0; k < AX; k++) begin
        s3_di_r[k] <= DIFF_W'(s2_p_r[k]) - DIFF_W'($signed(row_i_r[ppw_pkg::W_ORG+k]));
        s3_dj_r[k] <= DIFF_W'(s2_p_r[k]) - DIFF_W'($signed(row_j_r[ppw_pkg::W_ORG+k]));
        s3_ni_r[k] <= $signed(row_i_r[ppw_pkg::W_N+k][DW-1:0]);
        s3_nj_r[k] <= $signed(row_j_r[ppw_pkg::W_N+k][DW-1:0]);
        s3_tj_r[k] <= $signed(row_j_r[ppw_pkg::W_T+k][DW-1:0]);
        s3_sj_r[k] <= $signed(row_j_r[ppw_pkg::W_S+k][DW-1:0]);
        s3_oj_r[k] <= $signed(row_j_r[ppw_pkg::W_ORG+k]);
      end
    end

    if (rdy[4]) begin
      s4_is_wrap_r <= s3_is_wrap_r;
      s4_test_r    <= s3_test_r;
      s4_p_r       <= s3_p_r;
      s4_nj_r      <= s3_nj_r;
      s4_tj_r      <= s3_tj_r;
      s4_sj_r      <= s3_sj_r;
      s4_oj_r      <= s3_oj_r;
      for (int k = 0; k < AX; k++) begin
        s4_mn_r[k] <= PROD1_W'(s3_di_r[k]) * PROD1_W'(s3_ni_r[k]);
        s4_mt_r[k] <= PROD1_W'(s3_dj_r[k]) * PROD1_W'(s3_tj_r[k]);
        s4_ms_r[k] <= PROD1_W'(s3_dj_r[k]) * PROD1_W'(s3_sj_r[k]);
      end
    end

    if (rdy[5]) begin
      s5_is_wrap_r <= s4_is_wrap_r;
      s5_test_r    <= s4_test_r;
      s5_p_r       <= s4_p_r;
      s5_nj_r      <= s4_nj_r;
      s5_tj_r      <= s4_tj_r;
      s5_sj_r      <= s4_sj_r;
      s5_oj_r      <= s4_oj_r;
      s5_dn_r <= DOT_W'(s4_mn_r[0]) + DOT_W'(s4_mn_r[1]) + DOT_W'(s4_mn_r[2]);
      s5_dt_r <= DOT_W'(s4_mt_r[0]) + DOT_W'(s4_mt_r[1]) + DOT_W'(s4_mt_r[2]);
      s5_ds_r <= DOT_W'(s4_ms_r[0]) + DOT_W'(s4_ms_r[1]) + DOT_W'(s4_ms_r[2]);
    end

    // crossing test on the exact dot product, then round to Q21.16
    if (rdy[6]) begin
      s6_is_wrap_r <= s5_is_wrap_r;
      s6_wrap_r    <= s5_test_r && s5_dn_r[DOT_W-1];
      s6_p_r       <= s5_p_r;
      s6_nj_r      <= s5_nj_r;
      s6_tj_r      <= s5_tj_r;
      s6_sj_r      <= s5_sj_r;
      s6_oj_r      <= s5_oj_r;
      s6_qn_r      <= round_dot(s5_dn_r);
      s6_qt_r      <= round_dot(s5_dt_r);
      s6_qs_r      <= round_dot(s5_ds_r);
    end

    if (rdy[7]) begin
      s7_is_wrap_r <= s6_is_wrap_r;
      s7_wrap_r    <= s6_wrap_r;
      s7_p_r       <= s6_p_r;
      s7_oj_r      <= s6_oj_r;
      for (int k = 0; k < AX; k++) begin
        s7_mn_r[k] <= PROD2_W'(s6_qn_r) * PROD2_W'(s6_nj_r[k]);
        s7_mt_r[k] <= PROD2_W'(s6_qt_r) * PROD2_W'(s6_tj_r[k]);
        s7_ms_r[k] <= PROD2_W'(s6_qs_r) * PROD2_W'(s6_sj_r[k]);
      end
    end

    // normal component flips sign across the pair, rounding bias folded in
    if (rdy[8]) begin
      s8_is_wrap_r <= s7_is_wrap_r;
      s8_wrap_r    <= s7_wrap_r;
      s8_p_r       <= s7_p_r;
      s8_oj_r      <= s7_oj_r;
      for (int k = 0; k < AX; k++) begin
        s8_acc_r[k] <= ACC_W'(s7_mt_r[k]) + ACC_W'(s7_ms_r[k]) - ACC_W'(s7_mn_r[k]) +
                       ACC_W'(ppw_pkg::ROUND_HALF);
      end
    end

    if (rdy[9]) begin
      out_r <= out_nxt;
    end
  end

  // remapped coordinate, saturation and result select
  logic signed [RES_W-1:0] res [AX];
  logic signed [CW-1:0]    res_sat [AX];
  logic [AX-1:0]           clamp;

  always_comb begin
    for (int k = 0; k < AX; k++) begin
      res[k] = RES_W'(s8_oj_r[k]) + RES_W'($signed(s8_acc_r[k][ACC_W-1:FW]));
      if (res[k] > RES_W'(ppw_pkg::COORD_MAX)) begin
        res_sat[k] = ppw_pkg::COORD_MAX;
        clamp[k]   = 1'b1;
      end else if (res[k] < RES_W'(ppw_pkg::COORD_MIN)) begin
        res_sat[k] = ppw_pkg::COORD_MIN;
        clamp[k]   = 1'b1;
      end else begin
        res_sat[k] = CW'(res[k]);
        clamp[k]   = 1'b0;
      end
    end

    out_nxt = '0;
    if (s8_is_wrap_r) begin
      if (s8_wrap_r) begin
        out_nxt.x         = res_sat[0];
        out_nxt.y         = res_sat[1];
        out_nxt.z         = res_sat[2];
        out_nxt.wrapped   = 1'b1;
        out_nxt.saturated = |clamp;
      end else begin
        out_nxt.x = s8_p_r[0];
        out_nxt.y = s8_p_r[1];
        out_nxt.z = s8_p_r[2];
      end
    end
  end

  assign out_if.valid     = vld_r[STAGES];
  assign out_if.out_x     = out_r.x;
  assign out_if.out_y     = out_r.y;
  assign out_if.out_z     = out_r.z;
  assign out_if.wrapped   = out_r.wrapped;
  assign out_if.saturated = out_r.saturated;

  `PPW_CHECK_IMP(a_ready_low_full, !in_if.ready, vld_r[1], "ready low, stage 1 empty")
  `PPW_CHECK_IMP(a_sat_wrap, out_if.valid && out_if.saturated, out_if.wrapped, "clamp, no remap")
  `PPW_CHECK_NEXT(a_partner_clr, partner_set && !val_ok, !partner_vld_r[$past(in_idx)], "partner kept")

endmodule

FILE: tb/ppw_wrap_checker.sv
// result checker for the periodic plane wrap unit: mirrors the plane table, predicts
// every result in request order and compares it with what the unit returns
// depends on ppw_pkg and the channel interfaces in ppw_intf
`timescale 1ns / 1ps

module ppw_wrap_checker
  import ppw_pkg::*;
#(
  parameter int PLANES = PLANES_DEF
) (
  input  logic clk,
  input  logic rst_n,
  ppw_in_if    in_ch,
  ppw_out_if   out_ch,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      wrapped;
    logic                      saturated;
  } point_result_t;

  logic [COORD_W-1:0] geo_table [PLANES][WORDS];
  logic               has_partner [PLANES];
  int unsigned        partner_of [PLANES];
  point_result_t      result_q [$];
  point_result_t      want;
  point_result_t      got;
  int                 mismatches;

  function automatic longint coord_word(int pl, int w);
    return longint'(signed'(geo_table[pl][w]));
  endfunction

  // direction words carry Q2.16 in their low bits, the rest is ignored
  function automatic longint dir_word(int pl, int w);
    logic signed [DIR_W-1:0] d;
    d = geo_table[pl][w][DIR_W-1:0];
    return longint'(d);
  endfunction

  // exact dot(p - origin, axis), 32 fraction bits
  function automatic longint project(int pl, longint px, longint py, longint pz, int axis0);
    return (px - coord_word(pl, W_ORG))     * dir_word(pl, axis0)
         + (py - coord_word(pl, W_ORG + 1)) * dir_word(pl, axis0 + 1)
         + (pz - coord_word(pl, W_ORG + 2)) * dir_word(pl, axis0 + 2);
  endfunction

  // nearest, ties toward plus infinity
  function automatic longint round_q16(longint v);
    return (v + ROUND_HALF) >>> FRAC_W;
  endfunction

  function automatic point_result_t wrap_point(int pl, longint px, longint py, longint pz);
    point_result_t r;
    longint        pos [AXES];
    longint        pn;
    longint        pt;
    longint        ps;
    longint        acc;
    longint        v;
    int            j;
    int            k;
    pos[0] = px;
    pos[1] = py;
    pos[2] = pz;
    r.wrapped   = 1'b0;
    r.saturated = 1'b0;
    // sign test on the unrounded distance
    if (pl < PLANES && has_partner[pl] && project(pl, px, py, pz, W_N) < 0) begin
      j  = partner_of[pl];
      pn = round_q16(project(pl, px, py, pz, W_N));
      pt = round_q16(project(j, px, py, pz, W_T));
      ps = round_q16(project(j, px, py, pz, W_S));
      r.wrapped = 1'b1;
      for (k = 0; k < AXES; k++) begin
        acc = -pn * dir_word(j, W_N + k) + pt * dir_word(j, W_T + k)
            + ps * dir_word(j, W_S + k);
        v = coord_word(j, W_ORG + k) + round_q16(acc);
        if (v > longint'(COORD_MAX)) begin
          v = COORD_MAX;
          r.saturated = 1'b1;
        end else if (v < longint'(COORD_MIN)) begin
          v = COORD_MIN;
          r.saturated = 1'b1;
        end
        pos[k] = v;
      end
    end
    r.x = pos[0][COORD_W-1:0];
    r.y = pos[1][COORD_W-1:0];
    r.z = pos[2][COORD_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < PLANES; p++) begin
        has_partner[p] = 1'b0;
        partner_of[p]  = 0;
      end
      mismatches = 0;
      result_q.delete();
    end else begin
      // a result never belongs to the request taken at the same edge
      if (out_ch.valid && out_ch.ready) begin
        got.x         = out_ch.out_x;
        got.y         = out_ch.out_y;
        got.z         = out_ch.out_z;
        got.wrapped   = out_ch.wrapped;
        got.saturated = out_ch.saturated;
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result with no request pending: x=%0d y=%0d z=%0d w=%0b s=%0b",
                     $realtime, got.x, got.y, got.z, got.wrapped, got.saturated);
        end else begin
          want = result_q.pop_front();
          if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
              got.wrapped !== want.wrapped || got.saturated !== want.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: exp %0d %0d %0d w=%0b s=%0b got %0d %0d %0d w=%0b s=%0b",
                       $realtime, want.x, want.y, want.z, want.wrapped, want.saturated,
                       got.x, got.y, got.z, got.wrapped, got.saturated);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want = '0;
        case (in_ch.cmd)
          CMD_WRITE: begin
            if (in_ch.plane < PLANES && in_ch.word < WORDS)
              geo_table[in_ch.plane][in_ch.word] = in_ch.value;
          end
          CMD_PARTNER: begin
            if (in_ch.plane < PLANES) begin
              if (in_ch.value >= 0 && in_ch.value < PLANES) begin
                has_partner[in_ch.plane] = 1'b1;
                partner_of[in_ch.plane]  = in_ch.value;
              end else begin
                has_partner[in_ch.plane] = 1'b0;
                partner_of[in_ch.plane]  = 0;
              end
            end
          end
          CMD_WRAP: want = wrap_point(in_ch.plane, in_ch.point_x, in_ch.point_y, in_ch.point_z);
          default: ;
        endcase
        result_q.push_back(want);
      end
    end
    pending    <= result_q.size();
    fail_count <= mismatches;
  end

endmodule

FILE: tb/testbench.sv
// top of the periodic plane wrap unit testbench: clock, reset, request stimulus,
// result-side stalls, watchdog and verdict; checking lives in ppw_wrap_checker
// depends on ppw_pkg, ppw_intf and the unit itself
`timescale 1ns / 1ps

module testbench;
  import ppw_pkg::*;

  localparam int ITEMS       = 1670;
  localparam int CALM_ITEMS  = 300;
  localparam int QUIET_LIMIT = 200;
  localparam int TAIL_CYCLES = 20;

  localparam logic [31:0] BOX_LEN  = 32'h0064_0000;  // 100.0
  localparam logic [31:0] ONE      = 32'h0001_0000;
  localparam logic [31:0] NEG_ONE  = 32'hFFFF_0000;
  localparam logic [31:0] HALF     = 32'h0000_8000;
  localparam logic [31:0] NEG_HALF = 32'hFFFF_8000;
  localparam logic [31:0] DIR_TOP  = 32'h0001_FFFF;  // largest Q2.16 value

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   pending;
  bit   calm;
  int   send_idle_pct;
  int   quiet_cycles;

  ppw_in_if  in_ch ();
  ppw_out_if out_ch ();

  periodic_plane_wrap_unit #(.PLANES(PLANES_DEF)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  ppw_wrap_checker #(.PLANES(PLANES_DEF)) wrap_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return COORD_MAX;
      1: return COORD_MIN;
      2, 3: return $urandom();
      default: return $urandom_range(0, 32'h07FF_FFFF) - 32'h0400_0000;
    endcase
  endfunction

  function automatic logic [31:0] rand_dir();
    logic signed [DIR_W-1:0] d;
    logic [31:0]             w;
    case ($urandom_range(0, 5))
      0: d = DIR_W'(ONE);
      1: d = DIR_W'(NEG_ONE);
      2: d = '0;
      3: d = DIR_W'($urandom());
      default: d = DIR_W'($urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
    endcase
    w = 32'(d);
    // junk above the direction bits must be ignored
    if ($urandom_range(0, 3) == 0)
      w[31:DIR_W] = (32 - DIR_W)'($urandom());
    return w;
  endfunction

  // planes 0/1 form a periodic x box, 2/3 a y box with half-weight tangents
  // (rounding ties), 13 wraps into 14 which sits at the coordinate extremes
  function automatic logic [31:0] plane_seed(int pl, int w);
    if (pl <= 1) begin
      case (w)
        W_ORG:        return pl == 1 ? BOX_LEN : '0;
        W_N:          return pl == 0 ? ONE : NEG_ONE;
        W_T + 1:      return ONE;
        W_S + 2:      return ONE;
        default:      return '0;
      endcase
    end else if (pl <= 3) begin
      case (w)
        W_ORG + 1:    return pl == 3 ? BOX_LEN : '0;
        W_N + 1:      return pl == 2 ? ONE : NEG_ONE;
        W_T, W_T + 2: return HALF;
        W_S:          return HALF;
        W_S + 2:      return NEG_HALF;
        default:      return '0;
      endcase
    end else if (pl == 13) begin
      return w == W_N ? ONE : '0;
    end else if (pl == 14) begin
      case (w)
        W_ORG:        return COORD_MAX;
        W_ORG + 1:    return COORD_MIN;
        W_N, W_T + 1, W_S + 2: return DIR_TOP;
        default:      return '0;
      endcase
    end
    return w < W_N ? rand_coord() : rand_dir();
  endfunction

  task automatic send_request(cmd_t cmd, logic [PLANE_W-1:0] plane, logic [WORD_W-1:0] word,
                              logic [31:0] value, logic [31:0] px, logic [31:0] py,
                              logic [31:0] pz);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= cmd;
    in_ch.plane   <= plane;
    in_ch.word    <= word;
    in_ch.value   <= value;
    in_ch.point_x <= px;
    in_ch.point_y <= py;
    in_ch.point_z <= pz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wrap_at(int plane, logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_request(CMD_WRAP, PLANE_W'(plane), WORD_W'($urandom()), $urandom(), px, py, pz);
  endtask

  task automatic set_partner(int plane, logic [31:0] value);
    send_request(CMD_PARTNER, PLANE_W'(plane), WORD_W'($urandom()), value,
                 $urandom(), $urandom(), $urandom());
  endtask

  task automatic write_word(int plane, int word, logic [31:0] value);
    send_request(CMD_WRITE, PLANE_W'(plane), WORD_W'(word), value,
                 $urandom(), $urandom(), $urandom());
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_random_request();
    int                 pick;
    int                 w;
    logic [31:0]        v;
    pick = $urandom_range(0, 99);
    w    = $urandom_range(0, WORDS - 1);
    if (pick < 5) begin
      send_request(CMD_NOP, PLANE_W'($urandom()), WORD_W'($urandom()), $urandom(),
                   $urandom(), $urandom(), $urandom());
    end else if (pick < 15) begin
      if ($urandom_range(0, 7) == 0)
        w = $urandom_range(WORDS, 15);
      v = w < W_N ? rand_coord() : (w < WORDS ? rand_dir() : $urandom());
      write_word($urandom_range(0, 15), w, v);
    end else if (pick < 23) begin
      case ($urandom_range(0, 7))
        0: v = '1;
        1: v = $urandom();
        2: v = $urandom_range(PLANES_DEF, 300);
        default: v = $urandom_range(0, PLANES_DEF - 1);
      endcase
      set_partner($urandom_range(0, 15), v);
    end else begin
      wrap_at($urandom_range(0, 15), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  // result side: bursts of back-pressure, none once the run is calm
  initial begin
    int stall_left;
    int cycle_cnt;
    int stall_pct;
    stall_left = 0;
    cycle_cnt  = 0;
    stall_pct  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      cycle_cnt++;
      if (cycle_cnt % 256 == 0)
        stall_pct = pick_idle_pct();
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 5);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    calm          = 1'b0;
    send_idle_pct = 0;
    rst_n         <= 1'b0;
    in_ch.valid   <= 1'b0;
    in_ch.cmd     <= CMD_NOP;
    in_ch.plane   <= '0;
    in_ch.word    <= '0;
    in_ch.value   <= '0;
    in_ch.point_x <= '0;
    in_ch.point_y <= '0;
    in_ch.point_z <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // load every geometry word so no wrap ever reads an unloaded entry
    send_idle_pct = 10;
    for (int pl = 0; pl < PLANES_DEF; pl++)
      for (int w = 0; w < WORDS; w++)
        write_word(pl, w, plane_seed(pl, w));
    for (int pl = 0; pl < PLANES_DEF; pl++) begin
      if (pl <= 3)
        set_partner(pl, pl ^ 1);
      else if (pl == 13)
        set_partner(pl, 14);
      else if (pl == 6 || pl == 14 || $urandom_range(0, 4) == 0)
        set_partner(pl, '1);
      else
        set_partner(pl, $urandom_range(0, PLANES_DEF - 1));
    end

    // directed cases
    send_request(CMD_NOP, PLANE_W'($urandom()), WORD_W'($urandom()), $urandom(),
                 $urandom(), $urandom(), $urandom());
    wrap_at(0, 32'hFFFB_0000, 32'h0007_4000, 32'hFFFC_8000);  // behind the x=0 face
    wrap_at(0, 32'h0005_0000, 32'h0007_4000, 32'hFFFC_8000);  // inside the box
    wrap_at(0, 32'h0000_0000, $urandom(), $urandom());        // exactly on the face
    wrap_at(1, 32'h0067_0000, NEG_ONE, 32'h0002_0000);        // past the far face
    wrap_at(2, 32'hFFFF_FFFD, 32'hFFFF_DFFF, 32'h0000_0005);  // rounding ties
    wrap_at(2, 32'h0000_0003, 32'hFFFE_8000, 32'h0000_0007);
    write_word(5, 12, $urandom());                            // words past the row
    write_word(5, 15, $urandom());
    set_partner(6, '1);
    wrap_at(6, COORD_MAX, COORD_MIN, 32'hFFFF_FFFF);
    wrap_at(6, '0, '0, '0);
    set_partner(7, PLANES_DEF);
    wrap_at(7, rand_coord(), rand_coord(), rand_coord());
    set_partner(7, 32'h7FFF_FFFF);
    set_partner(7, 32'h8000_0000);
    set_partner(7, PLANES_DEF - 1);
    wrap_at(13, COORD_MIN, COORD_MAX, COORD_MIN);             // clamps on every axis
    wrap_at(13, COORD_MAX, '0, '0);
    set_partner(8, 8);                                        // plane partnered with itself
    wrap_at(8, rand_coord(), rand_coord(), rand_coord());
    wrap_at(8, rand_coord(), rand_coord(), rand_coord());

    // hold off until the unit is empty
    drain();

    for (int n = 0; n < ITEMS; n++) begin
      if (n == ITEMS - CALM_ITEMS) begin
        calm          = 1'b1;
        send_idle_pct = 0;
      end else if (!calm && n % 100 == 0) begin
        send_idle_pct = pick_idle_pct();
      end
      send_random_request();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/ppw_pkg.sv
rtl/ppw_intf.sv
rtl/periodic_plane_wrap_unit.sv
tb/ppw_wrap_checker.sv
tb/testbench.sv
